FILE: rtl/wcr_pkg.sv
`timescale 1ns / 1ps
package wcr_pkg;

	localparam int DEF_MAX_WIDTH  = 64;
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_MAX_KERNEL = 5;
	localparam int DEF_COEFF_BITS = 8;
	localparam int SLOT_COUNT     = 25;
	localparam int CFG_IDX_BITS   = 3;
	localparam int SUM_BITS       = 32;
	localparam int DIV_BITS       = 12;

	localparam logic [0:0] OP_STORE  = 1'b0;
	localparam logic [0:0] OP_FILTER = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_KSIZE   = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOTS0  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOTS1  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOTS2  = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_SLOT24  = 3'd7;

	localparam logic [7:0] CHAN_MAX = 8'd255;

	typedef struct packed {
		logic [0:0] opcode;
		logic [5:0] pos_x;
		logic [5:0] pos_y;
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
	} wcr_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic       coord_error;
	} wcr_out_t;

	// Control between the sequencer and the divider.
	typedef struct packed {
		logic                       start;
		logic signed [SUM_BITS-1:0] dividend;
		logic [DIV_BITS-1:0]        divisor;
	} wcr_div_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] value;
	} wcr_div_rsp_t;

endpackage

FILE: rtl/window_convolution_rgb_unit.sv
`timescale 1ns / 1ps
// Out of frame the flagged result is registered straight from idle; a store writes the
// pixel in its store state; a filter makes k*k window reads, then a drain state, three
// divisions on the shared divider and an output state.
// One item at a time: no new command is taken until the last result is out; busy falls in the strobe cycle.
// arst_n clears control and configuration; the pixel store is not cleared.
// The receiver cannot stall: each result shows for one cycle with done.
module window_convolution_rgb_unit
	import wcr_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int MAX_KERNEL = DEF_MAX_KERNEL,
	parameter int COEFF_BITS = DEF_COEFF_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  wcr_in_t                 cmd,
	output logic                    done,
	output wcr_out_t                result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [63:0]             cfg_data
);

	localparam int XB    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int YB    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int AB    = XB + YB;
	localparam int DEPTH = 2 ** AB;
	localparam int CB    = COEFF_BITS < 8 ? COEFF_BITS : 8;

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_READ  = 7'b0000010,
		ST_DRAIN = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_WAIT  = 7'b0010000,
		ST_OUT   = 7'b0100000,
		ST_STORE = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [6:0]   fw_q, fh_q;
	logic [2:0]   ks_q;
	logic [11:0]  div_q;
	logic [199:0] slots_q;

	// Registers change only between items.
	assign cfg_ready = !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q    <= 7'd64;
			fh_q    <= 7'd64;
			ks_q    <= 3'd3;
			div_q   <= 12'd1;
			slots_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WIDTH:   fw_q <= cfg_data[6:0];
				REG_HEIGHT:  fh_q <= cfg_data[6:0];
				REG_KSIZE: begin
					if (cfg_data[0] && 32'(cfg_data[2:0]) <= MAX_KERNEL)
						ks_q <= cfg_data[2:0];
				end
				REG_DIVISOR: begin
					if (cfg_data[11:0] != 12'd0) div_q <= cfg_data[11:0];
				end
				REG_SLOTS0:  slots_q[63:0]    <= cfg_data;
				REG_SLOTS1:  slots_q[127:64]  <= cfg_data;
				REG_SLOTS2:  slots_q[191:128] <= cfg_data;
				REG_SLOT24:  slots_q[199:192] <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Effective frame size: the configured size, clamped to MAX_WIDTH and MAX_HEIGHT.
	logic [10:0] ew, eh;
	assign ew = (11'(fw_q) < 11'(MAX_WIDTH)) ? 11'(fw_q) : 11'(MAX_WIDTH);
	assign eh = (11'(fh_q) < 11'(MAX_HEIGHT)) ? 11'(fh_q) : 11'(MAX_HEIGHT);

	wcr_in_t cmd_q;
	logic    outside;
	assign outside = (11'(cmd.pos_x) >= ew) || (11'(cmd.pos_y) >= eh);

	// Window walk counters: dx outer, dy inner, and the slot index.
	logic signed [3:0] dx_q, dy_q, half;
	logic [4:0]        slot_q;
	logic [4:0]        slot_s1;
	logic              rd_s1;
	logic [1:0]        ch_q;
	assign half = $signed({2'b00, ks_q[2:1]});

	// Clamped neighbor coordinates.
	logic signed [11:0] nx, ny;
	logic [XB-1:0] cx;
	logic [YB-1:0] cy;
	assign nx = $signed(12'(cmd_q.pos_x)) + 12'(dx_q);
	assign ny = $signed(12'(cmd_q.pos_y)) + 12'(dy_q);
	always_comb begin
		priority if (nx < 0) cx = '0;
		else if (nx >= $signed({1'b0, ew})) cx = XB'(ew - 11'd1);
		else cx = XB'(nx);
		priority if (ny < 0) cy = '0;
		else if (ny >= $signed({1'b0, eh})) cy = YB'(eh - 11'd1);
		else cy = YB'(ny);
	end

	// Pixel store: one write port and one read port, registered read.
	logic [23:0] mem [DEPTH];
	logic [23:0] rdata;
	logic        we;
	logic [AB-1:0] waddr, raddr;
	assign we    = (state_q == ST_STORE);
	assign waddr = {YB'(cmd_q.pos_y), XB'(cmd_q.pos_x)};
	assign raddr = {cy, cx};
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= {cmd_q.in_red, cmd_q.in_green, cmd_q.in_blue};
		rdata <= mem[raddr];
	end

	// Coefficient of the slot read last cycle.
	logic [7:0] raw_byte;
	logic signed [COEFF_BITS:0] coeff;
	assign raw_byte = slots_q[8*slot_s1 +: 8];
	always_comb begin
		if (COEFF_BITS > 8) coeff = $signed((COEFF_BITS+1)'(raw_byte));
		else coeff = (COEFF_BITS+1)'($signed(raw_byte[CB-1:0]));
	end

	logic signed [SUM_BITS-1:0] sr, sg, sb;
	wcr_mac #(.COEFF_BITS(COEFF_BITS)) u_mac (
		.clk(clk), .clear(state_q == ST_IDLE), .en(rd_s1), .pix(rdata),
		.coeff(coeff), .sum_r(sr), .sum_g(sg), .sum_b(sb)
	);

	wcr_div_req_t dreq;
	wcr_div_rsp_t drsp;
	always_comb begin
		dreq.start   = (state_q == ST_DIV);
		dreq.divisor = div_q;
		unique case (ch_q)
			2'd0:    dreq.dividend = sr;
			2'd1:    dreq.dividend = sg;
			default: dreq.dividend = sb;
		endcase
	end
	wcr_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic [7:0] res_r_q, res_g_q;

	assign busy = (state_q != ST_IDLE);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done    <= 1'b0;
			result  <= '0;
			cmd_q   <= '0;
			res_r_q <= '0;
			res_g_q <= '0;
			rd_s1   <= 1'b0;
			dx_q    <= '0;
			dy_q    <= '0;
			slot_q  <= '0;
			slot_s1 <= '0;
			ch_q    <= '0;
		end else begin
			done    <= 1'b0;
			rd_s1   <= 1'b0;
			slot_s1 <= slot_q;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						cmd_q <= cmd;
						dx_q  <= -half;
						dy_q  <= -half;
						slot_q <= '0;
						ch_q  <= '0;
						if (outside) begin
							result <= '{8'd0, 8'd0, 8'd0, 1'b1};
							done   <= 1'b1;
						end else if (cmd.opcode == OP_STORE) begin
							state_q <= ST_STORE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_STORE: begin
					result  <= '{8'd0, 8'd0, 8'd0, 1'b0};
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					rd_s1  <= 1'b1;
					slot_q <= slot_q + 5'd1;
					if (dy_q == half) begin
						dy_q <= -half;
						if (dx_q == half) state_q <= ST_DRAIN;
						else dx_q <= dx_q + 4'sd1;
					end else begin
						dy_q <= dy_q + 4'sd1;
					end
				end
				ST_DRAIN: state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_WAIT;
				ST_WAIT: begin
					if (drsp.done) begin
						ch_q <= ch_q + 2'd1;
						unique case (ch_q)
							2'd0:    res_r_q <= drsp.value;
							2'd1:    res_g_q <= drsp.value;
							default: begin
								result <= '{res_r_q, res_g_q, drsp.value, 1'b0};
							end
						endcase
						state_q <= (ch_q == 2'd2) ? ST_OUT : ST_DIV;
					end
				end
				ST_OUT: begin
					done    <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A result strobe never coincides with reading the window.
	a_done_not_read: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !rd_s1) else $error("strobe during window read");
	// Divider starts only from the sequencer's divide state.
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dreq.start |-> state_q == ST_DIV) else $error("stray divide");
	// Reads stop once the window is finished.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRAIN |=> !rd_s1) else $error("read after drain");

endmodule

FILE: rtl/wcr_divider.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle, truncation toward zero,
// result clamped to 0..255.
module wcr_divider
	import wcr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  wcr_div_req_t req,
	output wcr_div_rsp_t rsp
);

	localparam int CNT_BITS = $clog2(SUM_BITS + 1);

	logic [SUM_BITS-1:0] quo_q;
	logic [DIV_BITS:0]   rem_q;
	logic [DIV_BITS-1:0] dvs_q;
	logic                neg_q;
	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS:0]   trial;
	logic                fits;
	logic [7:0]          value;

	assign trial = {rem_q[DIV_BITS-1:0], quo_q[SUM_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	// Iterate one bit per cycle over the magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
			quo_q  <= '0;
			neg_q  <= 1'b0;
			dvs_q  <= '0;
			rem_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(SUM_BITS);
				quo_q  <= req.dividend[SUM_BITS-1] ? SUM_BITS'(-req.dividend)
					: SUM_BITS'(req.dividend);
				neg_q  <= req.dividend[SUM_BITS-1];
				dvs_q  <= req.divisor;
				rem_q  <= '0;
			end else if (busy_q) begin
				rem_q <= fits ? trial - {1'b0, dvs_q} : trial;
				quo_q <= {quo_q[SUM_BITS-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Clamp: a negative quotient gives zero, one above 255 gives 255.
	always_comb begin
		priority if (neg_q) value = 8'd0;
		else if (quo_q > SUM_BITS'(CHAN_MAX)) value = CHAN_MAX;
		else value = quo_q[7:0];
	end

	assign rsp = '{done: done_q, value: value};

endmodule

FILE: rtl/wcr_mac.sv
`timescale 1ns / 1ps
// Multiply-accumulate for the three channels, one coefficient shared by all three.
module wcr_mac
	import wcr_pkg::*;
#(
	parameter int COEFF_BITS = DEF_COEFF_BITS
) (
	input  logic                       clk,
	input  logic                       clear,
	input  logic                       en,
	input  logic [23:0]                pix,
	input  logic signed [COEFF_BITS:0] coeff,
	output logic signed [SUM_BITS-1:0] sum_r,
	output logic signed [SUM_BITS-1:0] sum_g,
	output logic signed [SUM_BITS-1:0] sum_b
);

	logic signed [SUM_BITS-1:0] c_ext;
	assign c_ext = SUM_BITS'(coeff);

	always_ff @(posedge clk) begin
		if (clear) begin
			sum_r <= '0;
			sum_g <= '0;
			sum_b <= '0;
		end else if (en) begin
			sum_r <= sum_r + $signed({24'd0, pix[23:16]}) * c_ext;
			sum_g <= sum_g + $signed({24'd0, pix[15:8]}) * c_ext;
			sum_b <= sum_b + $signed({24'd0, pix[7:0]}) * c_ext;
		end
	end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import wcr_pkg::*;

	localparam int FRAME_STRIDE   = 64;
	localparam int WATCHDOG_LIMIT = 4000;

	// Tracks the expected frame contents and configuration, and checks each result word.
	class conv_scoreboard;
		logic [23:0] pixels[FRAME_STRIDE*FRAME_STRIDE];
		int unsigned fw, fh, ksize, divisor;
		logic [63:0] slots[4];
		wcr_out_t    expected_q[$];
		int          errors, stores, filters, flagged;

		function new();
			fw = 64;
			fh = 64;
			ksize = 3;
			divisor = 1;
			foreach (slots[i]) slots[i] = '0;
			foreach (pixels[i]) pixels[i] = '0;
		endfunction

		function int eff_w();
			return (fw < FRAME_STRIDE) ? fw : FRAME_STRIDE;
		endfunction

		function int eff_h();
			return (fh < FRAME_STRIDE) ? fh : FRAME_STRIDE;
		endfunction

		// Mirror of a register write, including the writes that the block rejects.
		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] d);
			case (idx)
				REG_WIDTH: fw = 32'(d[6:0]);
				REG_HEIGHT: fh = 32'(d[6:0]);
				REG_KSIZE: begin
					if (d[0] && d[2:0] <= 3'd5) ksize = 32'(d[2:0]);
				end
				REG_DIVISOR: begin
					if (d[11:0] != 12'd0) divisor = 32'(d[11:0]);
				end
				REG_SLOTS0: slots[0] = d;
				REG_SLOTS1: slots[1] = d;
				REG_SLOTS2: slots[2] = d;
				REG_SLOT24: slots[3] = {56'd0, d[7:0]};
				default: ;
			endcase
		endfunction

		function logic [7:0] finish_chan(longint sum);
			longint q;
			q = sum / longint'(divisor);
			if (q < 0) return 8'd0;
			if (q > 255) return CHAN_MAX;
			return q[7:0];
		endfunction

		// Works out the result word for one accepted command.
		function void note_input(wcr_in_t c);
			wcr_out_t e;
			int half, nx, ny, s;
			longint sr, sg, sb, cf;
			logic [23:0] pix;
			logic [7:0] raw;
			e = '0;
			sr = 0;
			sg = 0;
			sb = 0;
			if (c.pos_x >= eff_w() || c.pos_y >= eff_h()) begin
				e.coord_error = 1'b1;
				flagged++;
			end else if (c.opcode == OP_STORE) begin
				pixels[c.pos_y*FRAME_STRIDE + c.pos_x] = {c.in_red, c.in_green, c.in_blue};
				stores++;
			end else begin
				half = ksize / 2;
				for (int dx = -half; dx <= half; dx++) begin
					for (int dy = -half; dy <= half; dy++) begin
						nx = int'(c.pos_x) + dx;
						ny = int'(c.pos_y) + dy;
						if (nx < 0) nx = 0;
						if (nx >= eff_w()) nx = eff_w() - 1;
						if (ny < 0) ny = 0;
						if (ny >= eff_h()) ny = eff_h() - 1;
						pix = pixels[ny*FRAME_STRIDE + nx];
						s = (dx + half) * ksize + (dy + half);
						raw = slots[s/8][(s%8)*8 +: 8];
						cf = longint'($signed(raw));
						sr += longint'(pix[23:16]) * cf;
						sg += longint'(pix[15:8]) * cf;
						sb += longint'(pix[7:0]) * cf;
					end
				end
				e.out_red = finish_chan(sr);
				e.out_green = finish_chan(sg);
				e.out_blue = finish_chan(sb);
				filters++;
			end
			expected_q.push_back(e);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(wcr_out_t r);
			wcr_out_t e;
			if (expected_q.size() == 0) begin
				report("result word with nothing pending");
			end else begin
				e = expected_q.pop_front();
				if (r.out_red !== e.out_red)
					report($sformatf("out_red %0h, expected %0h", r.out_red, e.out_red));
				if (r.out_green !== e.out_green)
					report($sformatf("out_green %0h, expected %0h", r.out_green, e.out_green));
				if (r.out_blue !== e.out_blue)
					report($sformatf("out_blue %0h, expected %0h", r.out_blue, e.out_blue));
				if (r.coord_error !== e.coord_error)
					report($sformatf("coord_error %0b, expected %0b", r.coord_error,
						e.coord_error));
			end
		endtask
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    start = 1'b0;
	logic                    busy;
	wcr_in_t                 cmd = '0;
	logic                    done;
	wcr_out_t                result;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [63:0]             cfg_data = '0;

	conv_scoreboard scb = new();
	bit             planned[FRAME_STRIDE*FRAME_STRIDE];
	int             idle_pct;
	int             idle_cycles = 0;

	window_convolution_rgb_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result words are checked before a command accepted on the same edge is noted.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) scb.check_result(result);
			if (start && !busy) scb.note_input(cmd);
		end
	end

	// Ends the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no activity for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end
	end

	task write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		scb.write_reg(idx, d);
		@(posedge clk);
	endtask

	// Holds start high until the command word is taken, with random gaps first.
	task send_item(wcr_in_t c);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	// Waits until every pending result word has come back.
	task settle();
		start <= 1'b0;
		@(posedge clk);
		while (scb.expected_q.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task store_px(int x, int y, logic [23:0] rgb);
		wcr_in_t c;
		c = '0;
		c.opcode = OP_STORE;
		c.pos_x = 6'(x);
		c.pos_y = 6'(y);
		{c.in_red, c.in_green, c.in_blue} = rgb;
		planned[y*FRAME_STRIDE + x] = 1'b1;
		send_item(c);
	endtask

	task filter_px(int x, int y);
		wcr_in_t c;
		c.opcode = OP_FILTER;
		c.pos_x = 6'(x);
		c.pos_y = 6'(y);
		{c.in_red, c.in_green, c.in_blue} = 24'($urandom);
		send_item(c);
	endtask

	// True when a filter here reads only pixels already stored, or is outside the frame.
	function automatic bit window_ok(int x, int y);
		int w, h, half, nx, ny;
		w = scb.eff_w();
		h = scb.eff_h();
		if (x >= w || y >= h) return 1'b1;
		half = scb.ksize / 2;
		for (int dx = -half; dx <= half; dx++) begin
			for (int dy = -half; dy <= half; dy++) begin
				nx = x + dx;
				ny = y + dy;
				if (nx < 0) nx = 0;
				if (nx >= w) nx = w - 1;
				if (ny < 0) ny = 0;
				if (ny >= h) ny = h - 1;
				if (!planned[ny*FRAME_STRIDE + nx]) return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	// Wide coefficients span the full byte; narrow ones stay in -8..8.
	function automatic logic [63:0] rand_slots(bit wide);
		logic [63:0] v;
		for (int i = 0; i < 8; i++)
			v[i*8 +: 8] = wide ? 8'($urandom) : 8'($urandom_range(16) - 8);
		return v;
	endfunction

	// Mostly in-region traffic, filters only where the window is fully stored.
	task run_random(int n);
		wcr_in_t c;
		int rx, ry, x, y;
		bit found;
		rx = (scb.eff_w() < 12) ? scb.eff_w() : 12;
		ry = (scb.eff_h() < 12) ? scb.eff_h() : 12;
		if (rx < 1) rx = 1;
		if (ry < 1) ry = 1;
		for (int i = 0; i < n; i++) begin
			{c.in_red, c.in_green, c.in_blue} = 24'($urandom);
			if ($urandom_range(9) == 0) begin
				x = $urandom_range(63);
				y = $urandom_range(63);
				c.opcode = 1'($urandom_range(1));
				if (c.opcode == OP_FILTER && !window_ok(x, y)) c.opcode = OP_STORE;
			end else begin
				found = 1'b0;
				if ($urandom_range(1)) begin
					for (int t = 0; t < 8 && !found; t++) begin
						x = $urandom_range(rx - 1);
						y = $urandom_range(ry - 1);
						found = window_ok(x, y);
					end
				end
				if (found) begin
					c.opcode = OP_FILTER;
				end else begin
					c.opcode = OP_STORE;
					x = $urandom_range(rx - 1);
					y = $urandom_range(ry - 1);
				end
			end
			c.pos_x = 6'(x);
			c.pos_y = 6'(y);
			if (c.opcode == OP_STORE && x < scb.eff_w() && y < scb.eff_h())
				planned[y*FRAME_STRIDE + x] = 1'b1;
			send_item(c);
		end
	endtask

	task run_phase(int w, int h, int k, int div, bit wide, int n, int pct);
		settle();
		write_cfg(REG_WIDTH, 64'(w));
		write_cfg(REG_HEIGHT, 64'(h));
		write_cfg(REG_KSIZE, 64'(k));
		write_cfg(REG_DIVISOR, 64'(div));
		write_cfg(REG_SLOTS0, rand_slots(wide));
		write_cfg(REG_SLOTS1, rand_slots(wide));
		write_cfg(REG_SLOTS2, rand_slots(wide));
		write_cfg(REG_SLOT24, rand_slots(wide));
		idle_pct = pct;
		run_random(n);
	endtask

	initial begin
		idle_pct = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Identity kernel on the corners; rejected size and divisor writes first.
		write_cfg(REG_KSIZE, 64'd4);
		write_cfg(REG_KSIZE, 64'd0);
		write_cfg(REG_KSIZE, 64'd7);
		write_cfg(REG_KSIZE, 64'd3);
		write_cfg(REG_DIVISOR, 64'd0);
		write_cfg(REG_DIVISOR, 64'd1);
		write_cfg(REG_WIDTH, 64'd64);
		write_cfg(REG_HEIGHT, 64'd64);
		write_cfg(REG_SLOTS0, 64'h0000_0001_0000_0000);
		write_cfg(REG_SLOTS1, '0);
		write_cfg(REG_SLOTS2, rand_slots(1'b1));
		write_cfg(REG_SLOT24, 64'hFF);
		store_px(0, 0, 24'hFFFFFF);
		store_px(1, 0, 24'h000000);
		store_px(0, 1, 24'h123456);
		store_px(1, 1, 24'hFF00FF);
		store_px(2, 0, 24'h0F0F0F);
		store_px(2, 1, 24'h808080);
		store_px(2, 2, 24'h00FFFF);
		store_px(0, 2, 24'h7F007F);
		store_px(1, 2, 24'h010203);
		store_px(63, 63, 24'hFF00FF);
		store_px(62, 63, 24'h00FF00);
		store_px(63, 62, 24'hAAAAAA);
		store_px(62, 62, 24'h555555);
		store_px(61, 61, 24'hC0C0C0);
		store_px(61, 62, 24'h3C3C3C);
		store_px(61, 63, 24'hFFFF00);
		store_px(62, 61, 24'h0000FF);
		store_px(63, 61, 24'hE01020);
		filter_px(0, 0);
		filter_px(1, 1);
		filter_px(63, 63);
		filter_px(62, 62);

		// Most negative and most positive coefficients saturate low and high.
		settle();
		write_cfg(REG_SLOTS0, {8{8'h80}});
		write_cfg(REG_SLOTS1, {8{8'h80}});
		filter_px(0, 0);
		filter_px(63, 63);
		settle();
		write_cfg(REG_SLOTS0, {8{8'h7F}});
		write_cfg(REG_SLOTS1, {8{8'h7F}});
		filter_px(0, 0);
		filter_px(63, 63);

		// Random phases over frame sizes, kernel sizes and divisors.
		run_phase(8, 8, 5, 1, 1'b0, 325, 15);
		run_phase(1, 1, 5, 4095, 1'b1, 150, 15);
		run_phase(64, 64, 1, 7, 1'b1, 250, 15);
		run_phase(5, 64, 3, 25, 1'b1, 325, 58);
		run_phase(64, 3, 5, 300, 1'b1, 300, 58);
		run_phase(0, 9, 3, 2, 1'b0, 50, 58);
		run_phase(16, 12, 3, 2, 1'b0, 300, 0);
		run_phase(127, 127, 5, 60, 1'b1, 215, 0);

		settle();
		repeat (200) @(posedge clk);
		if (scb.expected_q.size() != 0)
			scb.report($sformatf("%0d result words never arrived", scb.expected_q.size()));
		$display("Covered %0d stores, %0d filters and %0d out-of-frame commands",
			scb.stores, scb.filters, scb.flagged);
		$display("over eight frame and kernel settings; %0d mismatches", scb.errors);
		if (scb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/wcr_pkg.sv
rtl/wcr_divider.sv
rtl/wcr_mac.sv
rtl/window_convolution_rgb_unit.sv
test/tb_top.sv
